// ===== rtl/tsti_pkg.sv =====
// Package: table sizing, field widths, sequencer states and the symbol compare function.
package tsti_pkg;

  localparam int TABLE_DEPTH  = 128;
  localparam int SYMBOL_BYTES = 8;
  localparam int Q_FRAC       = 16;
  localparam int QUOT_W       = Q_FRAC + 1;
  localparam int ADDR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W        = ADDR_W + 1;
  localparam int STEP_W       = $clog2(QUOT_W);
  localparam int SYM_W        = 64;
  localparam int VOL_W        = 32;
  localparam int TIME_W       = 64;
  localparam int SLOT_W       = 7;
  localparam int IMB_W        = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [VOL_W-1:0]      mag;
    logic [VOL_W:0]        sum;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [QUOT_W-1:0]     quot;
  } div_rsp_t;

  // string compare over the first SYMBOL_BYTES bytes; a shared zero byte ends it
  function automatic logic sym_equal(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b);
    logic eq;
    logic stop;
    eq   = 1'b1;
    stop = 1'b0;
    for (int i = 0; i < SYMBOL_BYTES; i++) begin
      if (!stop) begin
        if (a[8*i +: 8] != b[8*i +: 8]) begin
          eq   = 1'b0;
          stop = 1'b1;
        end else if (a[8*i +: 8] == 8'd0) begin
          stop = 1'b1;
        end
      end
    end
    return eq;
  endfunction

endpackage

// ===== rtl/tsti_tick_if.sv =====
// Interface: tick input channel.
interface tsti_tick_if;
  import tsti_pkg::*;
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  symbol_text;
  logic [VOL_W-1:0]  bid_volume;
  logic [VOL_W-1:0]  ask_volume;
  logic [TIME_W-1:0] sent_time_ns;
  logic [TIME_W-1:0] arrival_time_ns;

  modport source (
    output valid, symbol_text, bid_volume, ask_volume, sent_time_ns, arrival_time_ns,
    input  ready
  );
  modport sink (
    input  valid, symbol_text, bid_volume, ask_volume, sent_time_ns, arrival_time_ns,
    output ready
  );
endinterface

// ===== rtl/tsti_result_if.sv =====
// Interface: result output channel.
interface tsti_result_if;
  import tsti_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SLOT_W-1:0]       slot_index;
  logic                    new_symbol;
  logic                    table_full_drop;
  logic [TIME_W-1:0]       latency_ns;
  logic signed [IMB_W-1:0] imbalance;
  logic                    zero_volume;

  modport source (
    output valid, slot_index, new_symbol, table_full_drop, latency_ns, imbalance,
           zero_volume,
    input  ready
  );
  modport sink (
    input  valid, slot_index, new_symbol, table_full_drop, latency_ns, imbalance,
           zero_volume,
    output ready
  );
endinterface

// ===== rtl/tsti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tsti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tsti_div.sv =====
// Restoring divider, one quotient bit per cycle: (mag << Q_FRAC) / sum.
module tsti_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsti_pkg::div_req_t req_i,
  output tsti_pkg::div_rsp_t rsp_o
);
  import tsti_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [VOL_W+1:0]    rem_q, rem_d;
  logic [VOL_W:0]      sum_q, sum_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;
  logic [VOL_W+1:0]    diff;
  logic                ge;

  assign ge   = rem_q >= {1'b0, sum_q};
  assign diff = rem_q - {1'b0, sum_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    sum_d  = sum_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = {2'b00, req_i.mag};
      sum_d  = req_i.sum;
      quot_d = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[QUOT_W-2:0], ge};
      rem_d  = ge ? {diff[VOL_W:0], 1'b0} : {rem_q[VOL_W:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sum_q  <= sum_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== rtl/tick_symbol_table_imbalance_top.sv =====
// Top level: symbol table lookup/append, latency and Q1.16 book imbalance per tick.
// Flow per accepted tick: the bit-serial divider runs, the symbol RAM is scanned over the occupied slots (skipped
// when empty, cut short on a match), the slot is written if found or room is left, then the result is registered.
// A new tick is taken only once the previous result has entered the output register; the scan does
// one read per cycle of the symbol RAM, and a stalled output register holds off the next tick.
// Reset clears the symbol count and all control; the symbol RAM itself is not cleared.
module tick_symbol_table_imbalance_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  tsti_tick_if.sink     tick_i,
  tsti_result_if.source result_o
);
  import tsti_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic                pend_q, pend_d;
  logic [ADDR_W-1:0]   pend_idx_q, pend_idx_d;
  logic                found_q, found_d;
  logic [ADDR_W-1:0]   slot_q, slot_d;

  logic [SYM_W-1:0]    sym_q;
  logic                neg_q;
  logic                zero_q;
  logic [TIME_W-1:0]   lat_q;

  logic                out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_new_q;
  logic                out_drop_q;
  logic [TIME_W-1:0]   out_lat_q;
  logic [IMB_W-1:0]    out_imb_q;
  logic                out_zero_q;

  logic                res_new_q, res_new_d;
  logic                res_drop_q, res_drop_d;

  logic                accept;
  logic                issue_ok;
  logic                hit;
  logic                last;
  logic                load_out;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SYM_W-1:0]    ram_rdata;
  logic [VOL_W:0]      vol_sum;
  logic [VOL_W-1:0]    vol_mag;
  logic [IMB_W-1:0]    imb_mag;
  logic [ADDR_W+SLOT_W-1:0] slot_wide;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign tick_i.ready = (state_q == ST_IDLE);
  assign accept       = tick_i.valid && tick_i.ready;

  assign vol_sum = {1'b0, tick_i.bid_volume} + {1'b0, tick_i.ask_volume};
  assign vol_mag = (tick_i.ask_volume > tick_i.bid_volume) ?
                   (tick_i.ask_volume - tick_i.bid_volume) :
                   (tick_i.bid_volume - tick_i.ask_volume);

  assign div_req.start = accept;
  assign div_req.mag   = vol_mag;
  assign div_req.sum   = vol_sum;

  tsti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tsti_ram #(
    .WIDTH (SYM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sym_q),
    .raddr_i (issue_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign issue_ok = issue_q < count_q;
  assign hit      = pend_q && sym_equal(ram_rdata, sym_q);
  assign last     = pend_q && ({1'b0, pend_idx_q} == (count_q - 1'b1));
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    slot_d     = slot_q;
    res_new_d  = res_new_q;
    res_drop_d = res_drop_q;
    ram_we     = 1'b0;
    ram_waddr  = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          issue_d = '0;
          found_d = 1'b0;
          state_d = (count_q == '0) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_d     = issue_ok;
        pend_idx_d = issue_q[ADDR_W-1:0];
        if (issue_ok) begin
          issue_d = issue_q + 1'b1;
        end
        if (hit) begin
          found_d = 1'b1;
          slot_d  = pend_idx_q;
          state_d = ST_WRITE;
        end else if (last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        res_new_d  = 1'b0;
        res_drop_d = 1'b0;
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = slot_q;
        end else if (count_q < CNT_W'(TABLE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[ADDR_W-1:0];
          slot_d    = count_q[ADDR_W-1:0];
          count_d   = count_q + 1'b1;
          res_new_d = 1'b1;
        end else begin
          slot_d     = '0;
          res_drop_d = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign imb_mag   = {{(IMB_W-QUOT_W){1'b0}}, div_rsp.quot};
  assign slot_wide = {{SLOT_W{1'b0}}, slot_q};

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    slot_q     <= slot_d;
    res_new_q  <= res_new_d;
    res_drop_q <= res_drop_d;
    if (accept) begin
      sym_q  <= tick_i.symbol_text;
      neg_q  <= tick_i.ask_volume > tick_i.bid_volume;
      zero_q <= (vol_sum == '0);
      lat_q  <= tick_i.arrival_time_ns - tick_i.sent_time_ns;
    end
    if (load_out) begin
      out_slot_q <= slot_wide[SLOT_W-1:0];
      out_new_q  <= res_new_q;
      out_drop_q <= res_drop_q;
      out_lat_q  <= lat_q;
      out_zero_q <= zero_q;
      if (zero_q) begin
        out_imb_q <= '0;
      end else begin
        out_imb_q <= neg_q ? (IMB_W'(0) - imb_mag) : imb_mag;
      end
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.slot_index      = out_slot_q;
  assign result_o.new_symbol      = out_new_q;
  assign result_o.table_full_drop = out_drop_q;
  assign result_o.latency_ns      = out_lat_q;
  assign result_o.imbalance       = out_imb_q;
  assign result_o.zero_volume     = out_zero_q;

endmodule

// ===== test/tick_symbol_table_imbalance_top_test.sv =====
// Testbench for tick_symbol_table_imbalance_top: tick traffic, table model and checks.
`timescale 1ns / 1ps

module tick_symbol_table_imbalance_top_test;
  import tsti_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol_text;
    logic [VOL_W-1:0]  bid_volume;
    logic [VOL_W-1:0]  ask_volume;
    logic [TIME_W-1:0] sent_time_ns;
    logic [TIME_W-1:0] arrival_time_ns;
  } tick_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       slot_index;
    logic                    new_symbol;
    logic                    table_full_drop;
    logic [TIME_W-1:0]       latency_ns;
    logic signed [IMB_W-1:0] imbalance;
    logic                    zero_volume;
  } book_result_t;

  logic clk_i;
  logic rst_ni;

  tsti_tick_if   tick_bus ();
  tsti_result_if result_bus ();

  tick_symbol_table_imbalance_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_bus),
    .result_o (result_bus)
  );

  tick_t        pending_ticks[$];
  book_result_t expected_results[$];

  logic [SYM_W-1:0] known_symbols [TABLE_DEPTH];
  int               known_count = 0;

  int          mismatches   = 0;
  int          ticks_sent   = 0;
  int          results_seen = 0;
  int          hold_left    = 0;
  logic        hold_started = 1'b0;
  book_result_t got;
  book_result_t want;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #20ms;
    $display("** tick_symbol_table_imbalance_top: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] wanted);
    $display("result %0d: %s got %0h expected %0h", results_seen, field, seen, wanted);
    mismatches++;
  endtask

  task automatic add_tick(tick_t t);
    pending_ticks.insert(pending_ticks.size(), t);
  endtask

  // C-string compare: bytes must agree up to and including a shared zero byte
  function automatic logic symbols_match(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b);
    for (int i = 0; i < SYMBOL_BYTES; i++) begin
      if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
      if (a[8*i +: 8] == 8'd0) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic book_result_t score_tick(tick_t t);
    book_result_t r;
    logic [VOL_W:0]   total;
    logic [VOL_W-1:0] spread;
    logic [48:0]      quot;
    logic             found;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < known_count && !found; i++) begin
      if (symbols_match(known_symbols[i], t.symbol_text)) begin
        known_symbols[i] = t.symbol_text;
        r.slot_index     = i[SLOT_W-1:0];
        found            = 1'b1;
      end
    end
    if (!found) begin
      if (known_count < TABLE_DEPTH) begin
        known_symbols[known_count] = t.symbol_text;
        r.slot_index               = known_count[SLOT_W-1:0];
        r.new_symbol               = 1'b1;
        known_count++;
      end else begin
        r.table_full_drop = 1'b1;
      end
    end
    r.latency_ns = t.arrival_time_ns - t.sent_time_ns;
    if (t.bid_volume == 0 && t.ask_volume == 0) begin
      r.zero_volume = 1'b1;
    end else begin
      total  = {1'b0, t.bid_volume} + {1'b0, t.ask_volume};
      spread = (t.ask_volume > t.bid_volume) ? t.ask_volume - t.bid_volume
                                             : t.bid_volume - t.ask_volume;
      quot   = {1'b0, spread, 16'd0} / {16'd0, total};
      r.imbalance = (t.ask_volume > t.bid_volume) ? -quot[IMB_W-1:0] : quot[IMB_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] make_symbol(int len);
    logic [SYM_W-1:0] s;
    s = '0;
    for (int i = 0; i < len; i++) s[8*i +: 8] = 8'($urandom_range(255, 1));
    return s;
  endfunction

  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return VOL_W'($urandom_range(3));
      3:       return '1 - VOL_W'($urandom_range(3));
      4, 5:    return VOL_W'($urandom_range(1000));
      default: return VOL_W'($urandom);
    endcase
  endfunction

  // tick driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_bus.valid && tick_bus.ready) begin
        expected_results.insert(expected_results.size(),
                                score_tick(pending_ticks.pop_front()));
        ticks_sent++;
      end
      if (!tick_bus.valid || tick_bus.ready) begin
        if (pending_ticks.size() != 0 &&
            ((ticks_sent >= 700 && ticks_sent < 1000) || $urandom_range(99) >= 8)) begin
          tick_bus.valid           <= 1'b1;
          tick_bus.symbol_text     <= pending_ticks[0].symbol_text;
          tick_bus.bid_volume      <= pending_ticks[0].bid_volume;
          tick_bus.ask_volume      <= pending_ticks[0].ask_volume;
          tick_bus.sent_time_ns    <= pending_ticks[0].sent_time_ns;
          tick_bus.arrival_time_ns <= pending_ticks[0].arrival_time_ns;
        end else begin
          tick_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long back-pressure stretch so the block fills and stalls its input
  always @(posedge clk_i) begin
    if (!hold_started && results_seen == 300) begin
      hold_left    <= 600;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        got.slot_index      = result_bus.slot_index;
        got.new_symbol      = result_bus.new_symbol;
        got.table_full_drop = result_bus.table_full_drop;
        got.latency_ns      = result_bus.latency_ns;
        got.imbalance       = result_bus.imbalance;
        got.zero_volume     = result_bus.zero_volume;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer, slot", 64'(got.slot_index), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
          if (got.new_symbol !== want.new_symbol)
            report_mismatch("new_symbol", 64'(got.new_symbol), 64'(want.new_symbol));
          if (got.table_full_drop !== want.table_full_drop)
            report_mismatch("table_full_drop", 64'(got.table_full_drop),
                            64'(want.table_full_drop));
          if (got.latency_ns !== want.latency_ns)
            report_mismatch("latency_ns", got.latency_ns, want.latency_ns);
          if (got.imbalance !== want.imbalance)
            report_mismatch("imbalance", 64'(unsigned'(got.imbalance)),
                            64'(unsigned'(want.imbalance)));
          if (got.zero_volume !== want.zero_volume)
            report_mismatch("zero_volume", 64'(got.zero_volume), 64'(want.zero_volume));
        end
        results_seen <= results_seen + 1;
      end
      result_bus.ready <= (hold_left == 0) &&
                          ((results_seen >= 700 && results_seen < 1000) ||
                           $urandom_range(99) >= 8);
    end
  end

  initial begin
    logic [SYM_W-1:0] pool [160];
    int               pool_len [160];
    tick_t            t;
    int               k;

    rst_ni                   = 1'b0;
    tick_bus.valid           = 1'b0;
    tick_bus.symbol_text     = '0;
    tick_bus.bid_volume      = '0;
    tick_bus.ask_volume      = '0;
    tick_bus.sent_time_ns    = '0;
    tick_bus.arrival_time_ns = '0;
    result_bus.ready         = 1'b0;

    // directed: terminator handling, empty symbol, volume and time extremes
    add_tick('{64'h00000000_4C504141, 32'd0, 32'd0, 64'd0, 64'd0});
    add_tick('{64'hDEADBE00_4C504141, '1, 32'd0, '1, 64'd0});
    add_tick('{64'h00000000_4C504141, 32'd0, '1, 64'd100, 64'd250});
    add_tick('{64'h48474645_44434241, '1, '1, 64'd5, 64'd4});
    add_tick('{64'h49474645_44434241, 32'd1, 32'd2, 64'd0, '1});
    add_tick('{64'h48474645_44434241, 32'd2, 32'd1, '1, '1});
    add_tick('{64'd0, 32'd1, '1, 64'd7, 64'd9});
    add_tick('{64'hFFFFFFFF_FFFFFF00, '1, 32'd1, 64'd9, 64'd7});
    add_tick('{64'hFFFFFFFF_FFFFFFFF, 32'd0, 32'd1, 64'd0, 64'd0});
    add_tick('{64'hFFFFFFFF_FFFFFFFE, 32'd1, 32'd0, 64'd0, 64'd0});
    add_tick('{64'h00FFFFFF_FFFFFFFF, 32'd3, 32'd7, 64'd0, 64'd1});
    add_tick('{64'hAAFFFFFF_FFFFFFFF, 32'd7, 32'd3, 64'd0, 64'd1});
    add_tick('{64'h00000000_00000041, 32'd0, 32'd0, '1, '1});
    add_tick('{64'h12340000_00000041, 32'h8000_0000, 32'h7FFF_FFFF, 64'd1, 64'd0});

    for (int i = 0; i < 160; i++) begin
      pool_len[i] = $urandom_range(8, 1);
      pool[i]     = make_symbol(pool_len[i]);
    end

    for (int n = 0; n < 1900; n++) begin
      k = $urandom_range(99);
      if (k < 75) begin
        k             = $urandom_range(159);
        t.symbol_text = pool[k];
        if (pool_len[k] < 7 && $urandom_range(1))
          t.symbol_text |= {$urandom, $urandom} << (8 * (pool_len[k] + 1));
      end else if (k < 88) begin
        t.symbol_text = {$urandom, $urandom};
      end else begin
        t.symbol_text = make_symbol($urandom_range(8, 1));
      end
      t.bid_volume   = pick_volume();
      t.ask_volume   = pick_volume();
      t.sent_time_ns = {$urandom, $urandom};
      if ($urandom_range(9) == 0)
        t.arrival_time_ns = {$urandom, $urandom};
      else
        t.arrival_time_ns = t.sent_time_ns + 64'($urandom_range(100000));
      add_tick(t);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ticks.size() != 0 || expected_results.size() != 0) @(negedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** tick_symbol_table_imbalance_top: PASSED **");
    end else begin
      $display("** tick_symbol_table_imbalance_top: FAILED **");
    end
    $finish;
  end

endmodule
